// File: sv/pixel_blend_and_format_pack_assert.svh
// ----------------------------------------------------------------------------
// Pixel blend and format pack: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_BLEND_AND_FORMAT_PACK_ASSERT_SVH
`define PIXEL_BLEND_AND_FORMAT_PACK_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PBF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication across the fixed pipeline latency
`define PBF_ASSERT_LAT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##LATENCY (cons)) else $error(msg);

`endif

// File: sv/pbf_pkg.sv
// ----------------------------------------------------------------------------
// Pixel blend and format pack: package
// Field widths, register indexes, layout codes and payload types.
// ----------------------------------------------------------------------------
package pbf_pkg;

	localparam int COORD_W    = 12;
	localparam int PITCH_W    = 15;
	localparam int OFFSET_W   = 26;
	localparam int WORD_W     = 32;
	localparam int SHIFT_W    = 5;
	localparam int BITS_W     = 4;
	localparam int LAYOUT_W   = 2;
	localparam int BE_W       = 4;
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int PIPE_DEPTH = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAYOUT = 3'd0,
		REG_PITCH  = 3'd1,
		REG_RSHIFT = 3'd2,
		REG_GSHIFT = 3'd3,
		REG_BSHIFT = 3'd4,
		REG_RBITS  = 3'd5,
		REG_GBITS  = 3'd6,
		REG_BBITS  = 3'd7
	} pbf_reg_t;

	typedef enum logic [LAYOUT_W-1:0] {
		LAYOUT_PACK3  = 2'd0,
		LAYOUT_PACK4  = 2'd1,
		LAYOUT_NATIVE = 2'd2
	} pbf_layout_t;

	localparam logic [BE_W-1:0]     BE_THREE     = 4'h7;
	localparam logic [BE_W-1:0]     BE_FOUR      = 4'hF;
	localparam logic [CH_W-1:0]     ALPHA_OPAQUE = 8'hFF;
	localparam logic [CH_W-1:0]     ALPHA_CLEAR  = 8'h00;
	localparam logic [BITS_W-1:0]   FULL_BITS    = 4'd8;
	localparam logic [14:0]         ROUND_BIAS   = 15'd127;

	localparam logic [LAYOUT_W-1:0] RST_LAYOUT = LAYOUT_NATIVE;
	localparam logic [PITCH_W-1:0]  RST_PITCH  = 15'd2560;
	localparam logic [SHIFT_W-1:0]  RST_RSHIFT = 5'd16;
	localparam logic [SHIFT_W-1:0]  RST_GSHIFT = 5'd8;
	localparam logic [SHIFT_W-1:0]  RST_BSHIFT = 5'd0;

	typedef struct packed {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [WORD_W-1:0]  scene_argb;
		logic [WORD_W-1:0]  overlay_argb;
		logic               overlay_on;
	} pbf_in_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] byte_offset;
		logic [WORD_W-1:0]   packed_word;
		logic [BE_W-1:0]     byte_enable;
	} pbf_out_t;

endpackage

// File: sv/pixel_blend_and_format_pack.sv
// ----------------------------------------------------------------------------
// Pixel blend and format pack
// Alpha blends an overlay pixel over a scene pixel, packs it for scanout
// and computes its byte offset in the frame.
// ----------------------------------------------------------------------------
// One pixel enters per clock and its result appears after the three register
// stages with done high for one cycle; busy is always low, so start may be
// held high every cycle. The three register stages are: blend multiplies and
// the row multiply, then the channel rescale multiply and the offset add,
// then the divide by 255 and bit placement. The receiver cannot stall and
// must take each result in the cycle done is high. Change registers only
// while no pixel is in flight.
module pixel_blend_and_format_pack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  pbf_pkg::pbf_in_t               in_item,
	output logic                           done,
	output pbf_pkg::pbf_out_t              result,
	input  logic                           wr_en,
	input  logic [pbf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pbf_pkg::CFG_DATA_W-1:0] wr_data
);
	import pbf_pkg::*;

	logic [LAYOUT_W-1:0] layout_q;
	logic [PITCH_W-1:0]  pitch_q;
	logic [SHIFT_W-1:0]  rshift_q, gshift_q, bshift_q;
	logic [BITS_W-1:0]   rbits_q, gbits_q, bbits_q;

	logic                valid_s1, valid_s2, valid_s3;
	logic [WORD_W-1:0]   argb_s1, argb_s2;
	logic [OFFSET_W-1:0] rowprod_s1, colprod_s1, offset_s2;
	logic [14:0]         rt_s2, gt_s2, bt_s2;
	logic [2:0]          pass_s2;
	pbf_out_t            res_s3;

	logic                three;
	logic [CH_W-1:0]     alpha, alpha_inv;
	logic [WORD_W-1:0]   mixed, argb_next;
	logic [OFFSET_W-1:0] col_next;
	logic [14:0]         rt_next, gt_next, bt_next;
	logic [CH_W-1:0]     rch, gch, bch;
	logic [WORD_W-1:0]   word_next;

	function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] o,
		input logic [CH_W-1:0] s, input logic [CH_W-1:0] a, input logic [CH_W-1:0] ia);
		logic [15:0] sum;
		sum = 16'(o) * 16'(a) + 16'(s) * 16'(ia);
		return sum[15:8];
	endfunction

	function automatic logic [14:0] scale_ch(input logic [CH_W-1:0] v,
		input logic [BITS_W-1:0] n);
		logic [CH_W-1:0] top;
		top = (8'd1 << n[2:0]) - 8'd1;
		if (n >= FULL_BITS) begin
			return 15'(v);
		end
		return 15'(v) * 15'(top) + ROUND_BIAS;
	endfunction

	function automatic logic [CH_W-1:0] div255(input logic [14:0] t);
		logic [15:0] sum;
		sum = 16'(t) + 16'(t[14:8]) + 16'd1;
		return sum[15:8];
	endfunction

	assign busy  = 1'b0;
	assign three = (layout_q == LAYOUT_PACK3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= RST_LAYOUT;
			pitch_q  <= RST_PITCH;
			rshift_q <= RST_RSHIFT;
			gshift_q <= RST_GSHIFT;
			bshift_q <= RST_BSHIFT;
			rbits_q  <= FULL_BITS;
			gbits_q  <= FULL_BITS;
			bbits_q  <= FULL_BITS;
		end else if (wr_en) begin
			case (pbf_reg_t'(wr_index))
				REG_LAYOUT: layout_q <= wr_data[LAYOUT_W-1:0];
				REG_PITCH:  pitch_q  <= wr_data[PITCH_W-1:0];
				REG_RSHIFT: rshift_q <= wr_data[SHIFT_W-1:0];
				REG_GSHIFT: gshift_q <= wr_data[SHIFT_W-1:0];
				REG_BSHIFT: bshift_q <= wr_data[SHIFT_W-1:0];
				REG_RBITS:  rbits_q  <= wr_data[BITS_W-1:0];
				REG_GBITS:  gbits_q  <= wr_data[BITS_W-1:0];
				REG_BBITS:  bbits_q  <= wr_data[BITS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		alpha     = in_item.overlay_argb[31:24];
		alpha_inv = ALPHA_OPAQUE - alpha;
		mixed = {ALPHA_OPAQUE,
			blend_ch(in_item.overlay_argb[23:16], in_item.scene_argb[23:16], alpha, alpha_inv),
			blend_ch(in_item.overlay_argb[15:8], in_item.scene_argb[15:8], alpha, alpha_inv),
			blend_ch(in_item.overlay_argb[7:0], in_item.scene_argb[7:0], alpha, alpha_inv)};
		if (!in_item.overlay_on || alpha == ALPHA_CLEAR) begin
			argb_next = in_item.scene_argb;
		end else if (alpha == ALPHA_OPAQUE) begin
			argb_next = in_item.overlay_argb;
		end else begin
			argb_next = mixed;
		end
		if (three) begin
			col_next = OFFSET_W'({in_item.px, 1'b0}) + OFFSET_W'(in_item.px);
		end else begin
			col_next = OFFSET_W'({in_item.px, 2'b00});
		end
	end

	always_comb begin
		rt_next = scale_ch(argb_s1[23:16], rbits_q);
		gt_next = scale_ch(argb_s1[15:8], gbits_q);
		bt_next = scale_ch(argb_s1[7:0], bbits_q);
	end

	always_comb begin
		rch = pass_s2[2] ? rt_s2[7:0] : div255(rt_s2);
		gch = pass_s2[1] ? gt_s2[7:0] : div255(gt_s2);
		bch = pass_s2[0] ? bt_s2[7:0] : div255(bt_s2);
		if (layout_q == LAYOUT_NATIVE) begin
			word_next = argb_s2;
		end else begin
			word_next = (WORD_W'(rch) << rshift_q) | (WORD_W'(gch) << gshift_q) |
				(WORD_W'(bch) << bshift_q);
			if (three) begin
				word_next[31:24] = ALPHA_CLEAR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		argb_s1    <= argb_next;
		rowprod_s1 <= OFFSET_W'(in_item.py) * OFFSET_W'(pitch_q);
		colprod_s1 <= col_next;

		argb_s2    <= argb_s1;
		offset_s2  <= rowprod_s1 + colprod_s1;
		rt_s2      <= rt_next;
		gt_s2      <= gt_next;
		bt_s2      <= bt_next;
		pass_s2    <= {rbits_q >= FULL_BITS, gbits_q >= FULL_BITS, bbits_q >= FULL_BITS};

		res_s3.byte_offset <= offset_s2;
		res_s3.packed_word <= word_next;
		res_s3.byte_enable <= three ? BE_THREE : BE_FOUR;
	end

	assign done   = valid_s3;
	assign result = res_s3;

endmodule

// File: sv/pbf_checker.sv
// ----------------------------------------------------------------------------
// Pixel blend and format pack: port checker
// Watches the top-level ports for latency and result format rules.
// ----------------------------------------------------------------------------
`include "pixel_blend_and_format_pack_assert.svh"

module pbf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input pbf_pkg::pbf_out_t result
);
	import pbf_pkg::*;

	localparam int LATENCY = PIPE_DEPTH;

	`PBF_ASSERT_LAT(a_transfer_yields_result, start && !busy, done, "transfer without result")
	`PBF_ASSERT_LAT(a_no_spurious_result, !(start && !busy), !done, "result without transfer")
	`PBF_ASSERT_IMP(a_enable_code, done, result.byte_enable == BE_THREE || result.byte_enable == BE_FOUR, "bad byte enable")
	`PBF_ASSERT_IMP(a_three_byte_top, done && result.byte_enable == BE_THREE, result.packed_word[31:24] == ALPHA_CLEAR, "top byte set in 3-byte word")

endmodule

bind pixel_blend_and_format_pack pbf_checker u_pbf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
